[rtl/rsi_pkg.sv]
package rsi_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int DIR_FRAC_BITS   = 14;

  // magnitude widths
  localparam int NUM_W = 50;   // |numerator| < 2^50
  localparam int DEN_W = 32;   // |denom| <= 2^31
  localparam int QUO_W = 33;   // quotient bits kept before saturation

  typedef struct packed {
    logic signed [31:0] ray_start_x;
    logic signed [31:0] ray_start_y;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic        [30:0] ray_max_len;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [15:0] seg_dir_x;
    logic signed [15:0] seg_dir_y;
    logic        [30:0] seg_len;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] ray_param;
    logic signed [31:0] seg_param;
    logic               degenerate;
  } out_word_t;

  // data travelling along the divider chain
  typedef struct packed {
    logic               vld;
    logic               degen;
    logic        [30:0] max_len;
    logic        [30:0] seg_len;
    logic               t_neg;
    logic               s_neg;
    logic [DEN_W-1:0]   den;
    logic [63:0]        t_rem;
    logic [63:0]        s_rem;
    logic [QUO_W-1:0]   t_quo;
    logic [QUO_W-1:0]   s_quo;
  } div_cell_t;

endpackage

[rtl/rsi_div_cell.sv]
// one restoring division step for both quotients
module rsi_div_cell #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  rsi_pkg::div_cell_t   d_in,
  output rsi_pkg::div_cell_t   d_out
);

  rsi_pkg::div_cell_t cell_r, cell_nxt;
  logic [64+rsi_pkg::DEN_W-1:0] sh_den;
  logic [63:0] t_rem, s_rem;
  logic t_ge, s_ge;

  // compare remainder against denominator shifted to this bit
  always_comb begin
    sh_den = {64'd0, d_in.den} << BIT;
    t_ge   = {{rsi_pkg::DEN_W{1'b0}}, d_in.t_rem} >= sh_den;
    s_ge   = {{rsi_pkg::DEN_W{1'b0}}, d_in.s_rem} >= sh_den;
    t_rem  = t_ge ? d_in.t_rem - sh_den[63:0] : d_in.t_rem;
    s_rem  = s_ge ? d_in.s_rem - sh_den[63:0] : d_in.s_rem;
    cell_nxt            = d_in;
    cell_nxt.t_rem      = t_rem;
    cell_nxt.s_rem      = s_rem;
    cell_nxt.t_quo[BIT] = t_ge;
    cell_nxt.s_quo[BIT] = s_ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

[rtl/ray_segment_intersect.sv]
// Ray against segment intersection test, fixed point.
// Input channel in_valid/in_ready/in_data carries one ray and one segment;
// output channel out_valid/out_ready/out_data returns hit, t, s and the
// parallel flag for each word, in order.
// Throughput: one word per cycle unless the output stalls; the chain of QUO_W
// restoring divider cells, one quotient bit per cell, makes up most of the pipeline.
// When out_ready is low and the last cell holds an undelivered word, the whole
// chain holds; in_ready falls only then, so no word is lost.
// Reset (rst_n low, synchronous) empties the chain; no warm-up pass.
// in_ready stays low while rst_n is low.
module ray_segment_intersect (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsi_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsi_pkg::out_word_t out_data
);

  localparam int QW = rsi_pkg::QUO_W;

  logic en;
  assign en       = out_ready || !out_valid;
  assign in_ready = en && rst_n;

  // stage 1: differences and products
  logic               s1_vld_r;
  logic signed [32:0] qx_r, qy_r;
  logic signed [15:0] dx_r, dy_r, lx_r, ly_r;
  logic signed [31:0] den_r;
  logic        [30:0] s1_max_r, s1_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r     <= 33'(in_data.seg_start_x) - 33'(in_data.ray_start_x);
      qy_r     <= 33'(in_data.seg_start_y) - 33'(in_data.ray_start_y);
      dx_r     <= in_data.ray_dir_x;
      dy_r     <= in_data.ray_dir_y;
      lx_r     <= in_data.seg_dir_x;
      ly_r     <= in_data.seg_dir_y;
      den_r    <= 32'(in_data.ray_dir_x * in_data.seg_dir_y)
                - 32'(in_data.ray_dir_y * in_data.seg_dir_x);
      s1_max_r <= in_data.ray_max_len;
      s1_len_r <= in_data.seg_len;
    end
  end

  // stage 2: four products
  logic               s2_vld_r;
  logic signed [48:0] p_qxly_r, p_qylx_r, p_qxdy_r, p_qydx_r;
  logic signed [31:0] s2_den_r;
  logic        [30:0] s2_max_r, s2_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_qxly_r <= 49'(qx_r * ly_r);
      p_qylx_r <= 49'(qy_r * lx_r);
      p_qxdy_r <= 49'(qx_r * dy_r);
      p_qydx_r <= 49'(qy_r * dx_r);
      s2_den_r <= den_r;
      s2_max_r <= s1_max_r;
      s2_len_r <= s1_len_r;
    end
  end

  // stage 3: numerators, signs and magnitudes into the chain
  logic signed [49:0] tn, sn;
  logic [49:0] tn_mag, sn_mag;
  logic [31:0] den_mag;
  rsi_pkg::div_cell_t head;

  always_comb begin
    tn      = 50'(p_qxly_r) - 50'(p_qylx_r);
    sn      = 50'(p_qxdy_r) - 50'(p_qydx_r);
    tn_mag  = tn[49] ? 50'(-tn) : 50'(tn);
    sn_mag  = sn[49] ? 50'(-sn) : 50'(sn);
    den_mag = s2_den_r[31] ? 32'(-s2_den_r) : 32'(s2_den_r);
    head          = '0;
    head.vld      = s2_vld_r;
    head.degen    = (s2_den_r == 32'sd0);
    head.max_len  = s2_max_r;
    head.seg_len  = s2_len_r;
    head.t_neg    = tn[49] ^ s2_den_r[31];
    head.s_neg    = sn[49] ^ s2_den_r[31];
    head.den      = head.degen ? 32'd1 : den_mag;
    head.t_rem    = 64'(tn_mag) << rsi_pkg::DIR_FRAC_BITS;
    head.s_rem    = 64'(sn_mag) << rsi_pkg::DIR_FRAC_BITS;
  end

  rsi_pkg::div_cell_t head_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else if (en) begin
      head_r <= head;
    end
  end

  // chain of divider cells, most significant quotient bit first
  rsi_pkg::div_cell_t link [QW+1];
  assign link[0] = head_r;

  // a quotient at or above 2^QW sets every bit and saturates anyway
  genvar g;
  generate
    for (g = 0; g < QW; g++) begin : g_cell
      rsi_div_cell #(.BIT(QW - 1 - g)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d_in  (link[g]),
        .d_out (link[g+1])
      );
    end
  endgenerate

  // saturation and bounds check on the chain's last word
  rsi_pkg::div_cell_t tail;
  logic t_big, s_big;
  logic signed [31:0] t_val, s_val;

  always_comb begin
    tail  = link[QW];
    // a remainder at or above den << QW means magnitude >= 2^QW
    t_big = tail.t_rem >= (64'(tail.den) << QW);
    s_big = tail.s_rem >= (64'(tail.den) << QW);
    if (tail.t_neg)
      t_val = (t_big || tail.t_quo > 33'h080000000) ? 32'sh80000000
            : 32'(-tail.t_quo);
    else
      t_val = (t_big || tail.t_quo > 33'h07fffffff) ? 32'sh7fffffff
            : 32'(tail.t_quo);
    if (tail.s_neg)
      s_val = (s_big || tail.s_quo > 33'h080000000) ? 32'sh80000000
            : 32'(-tail.s_quo);
    else
      s_val = (s_big || tail.s_quo > 33'h07fffffff) ? 32'sh7fffffff
            : 32'(tail.s_quo);
    out_data.degenerate = tail.degen;
    out_data.hit = !tail.degen && !t_val[31] && !s_val[31]
                 && (t_val <= $signed({1'b0, tail.max_len}))
                 && (s_val <= $signed({1'b0, tail.seg_len}));
    out_data.ray_param = out_data.hit ? t_val : $signed({1'b0, tail.max_len});
    out_data.seg_param = tail.degen ? 32'sd0 : s_val;
  end

  assign out_valid = tail.vld;

  // stalled output word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  // parallel inputs never hit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> !out_data.hit && out_data.seg_param == 0)
    else $error("degenerate word reported a hit");

  // hit implies non-negative parameters
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.ray_param[31] && !out_data.seg_param[31])
    else $error("hit with negative parameter");

endmodule
